>>> src/spb_pkg.sv
// Shared types and constants for the sample pair batcher.
// No dependencies; used by every module of the block but spb_ram.
`default_nettype none

package spb_pkg;

  localparam int CODE_W  = 24;
  localparam int STAMP_W = 48;
  localparam int DMS_W   = 8;
  localparam int GAP_W   = 8;
  localparam int CHAN_W  = 4;
  localparam int CNT_W   = 6;
  localparam int DIFF_W  = 18;
  localparam int RECIP_W = 11;
  localparam int PROD_W  = DIFF_W + RECIP_W;
  localparam int QEST_W  = 9;
  localparam int ENTRY_W = 2 * CODE_W + DMS_W;

  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_MS  = 11'd1048;
  localparam logic [DIFF_W-1:0]  US_PER_MS = 18'd1000;
  localparam logic [GAP_W-1:0]   GAP_RESET = 8'd255;

  localparam logic              CMD_RESTART = 1'b1;
  localparam logic [CHAN_W-1:0] CHAN_0      = 4'd0;
  localparam logic [CHAN_W-1:0] CHAN_1      = 4'd1;

  localparam logic CAUSE_FULL = 1'b0;
  localparam logic CAUSE_GAP  = 1'b1;

  typedef struct packed {
    logic               bank;
    logic [CNT_W-1:0]   count;
    logic               cause;
    logic [STAMP_W-1:0] stamp;
  } flush_cmd_t;

  typedef struct packed {
    logic       valid;
    flush_cmd_t cmd;
  } flush_req_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_release_t;

endpackage

`default_nettype wire

>>> src/sample_pair_batcher_core.sv
// Top level of the sample pair batcher: front end, flush queue, batch RAM, back end.
// Depends on spb_pkg, spb_front, spb_cmd_queue, spb_ram and spb_back.
//
// Usage: each input request is a conversion (channel, raw code, timestamp in us) or a
// restart. Codes of channels 0 and 1 are paired; pairs collect in a batch with the whole
// ms since batch start. A full batch, or one overtaken by the gap in cfg_wdata (written
// with cfg_we while idle), leaves on the out_ channel as a run of entries, last one marked.
// Input: a restart, a discarded channel or a conversion that completes no pair is taken
// while the front end stays in F_IDLE; one that completes a pair passes F_DIFF, F_MUL,
// F_CORR and F_WRITE, waiting in F_WRITE while the batch bank it goes into is still being
// drained (two banks alternate, so a stalled receiver blocks the input only once two
// batches wait). Output: the back end pops the flush request from the queue, reads the
// first entry from the RAM, loads the output register and offers it; each further entry
// is read once the one before is taken, the RAM read being registered ahead of the output register.
// When the receiver stalls, the output entry holds and the queue and banks absorb up to
// one further batch. Reset (rst_n low at a clock edge) clears the pairing flags, the batch,
// pending flushes and sets the gap limit to 255 ms; no clearing pass is needed.
`default_nettype none

module sample_pair_batcher_core #(
  parameter int BATCH_DEPTH = 8,
  parameter int TIME_BITS   = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_cmd,
  input  wire logic [spb_pkg::CHAN_W-1:0]   in_channel,
  input  wire logic [spb_pkg::CODE_W-1:0]   in_raw_code,
  input  wire logic [spb_pkg::STAMP_W-1:0]  in_now_us,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [spb_pkg::CODE_W-1:0]   out_ch0_code,
  output logic      [spb_pkg::CODE_W-1:0]   out_ch1_code,
  output logic      [spb_pkg::DMS_W-1:0]    out_delta_ms,
  output logic      [spb_pkg::STAMP_W-1:0]  out_start_time_us,
  output logic                              out_flush_cause,
  output logic                              out_last,
  input  wire logic                         cfg_we,
  input  wire logic [spb_pkg::GAP_W-1:0]    cfg_wdata
);

  localparam int IDX_W     = $clog2(BATCH_DEPTH);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [spb_pkg::ENTRY_W-1:0]   wr_data;
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  logic [spb_pkg::ENTRY_W-1:0]   rd_data;
  spb_pkg::flush_req_t           flush_req;
  spb_pkg::flush_cmd_t           q_head;
  logic                          q_not_empty;
  logic                          q_pop;
  spb_pkg::bank_release_t        release_bank;

  spb_front #(
    .BATCH_DEPTH (BATCH_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_channel   (in_channel),
    .in_raw_code  (in_raw_code),
    .in_now_us    (in_now_us),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .flush_req    (flush_req),
    .release_bank (release_bank)
  );

  spb_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (flush_req),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  spb_ram #(
    .WIDTH (spb_pkg::ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spb_back #(
    .BATCH_DEPTH (BATCH_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .release_bank      (release_bank),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ch0_code      (out_ch0_code),
    .out_ch1_code      (out_ch1_code),
    .out_delta_ms      (out_delta_ms),
    .out_start_time_us (out_start_time_us),
    .out_flush_cause   (out_flush_cause),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

>>> src/spb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spb_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/spb_front.sv
// Front end: takes requests, pairs channel codes, times them and fills the batch banks.
// Depends on spb_pkg; drives spb_ram writes and pushes flush requests to spb_cmd_queue.
`default_nettype none

module spb_front #(
  parameter int BATCH_DEPTH = 8,
  parameter int TIME_BITS   = 48,
  localparam int IDX_W  = $clog2(BATCH_DEPTH),
  localparam int FILL_W = $clog2(BATCH_DEPTH + 1),
  localparam int ADDR_W = IDX_W + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_cmd,
  input  wire logic [spb_pkg::CHAN_W-1:0]    in_channel,
  input  wire logic [spb_pkg::CODE_W-1:0]    in_raw_code,
  input  wire logic [spb_pkg::STAMP_W-1:0]   in_now_us,
  input  wire logic                          cfg_we,
  input  wire logic [spb_pkg::GAP_W-1:0]     cfg_wdata,
  output logic                               wr_en,
  output logic      [ADDR_W-1:0]             wr_addr,
  output logic      [spb_pkg::ENTRY_W-1:0]   wr_data,
  output spb_pkg::flush_req_t                flush_req,
  input  wire spb_pkg::bank_release_t        release_bank
);

  typedef enum logic [2:0] {F_IDLE, F_DIFF, F_MUL, F_CORR, F_WRITE} front_state_t;

  function automatic logic [spb_pkg::DIFF_W-1:0] gap_to_thresh(
    input logic [spb_pkg::GAP_W-1:0] gap
  );
    return (spb_pkg::DIFF_W'(gap) + spb_pkg::DIFF_W'(1)) * spb_pkg::US_PER_MS;
  endfunction

  front_state_t                   state_r;
  logic [1:0]                     flags_r;
  logic [1:0]                     flags_set;
  logic [spb_pkg::CODE_W-1:0]     held0_r;
  logic [spb_pkg::CODE_W-1:0]     held1_r;
  logic [FILL_W-1:0]              fill_r;
  logic                           bank_r;
  logic [1:0]                     busy_r;
  logic [1:0]                     busy_nxt;
  logic [spb_pkg::DIFF_W-1:0]     thresh_r;
  logic [TIME_BITS-1:0]           start_r;
  logic [TIME_BITS-1:0]           now_r;
  logic [TIME_BITS-1:0]           now_t;
  logic [TIME_BITS-1:0]           start_eff;
  logic [TIME_BITS-1:0]           diff;
  logic                           over_now;
  logic [spb_pkg::DIFF_W-1:0]     diff_lo_r;
  logic                           over_r;
  logic [spb_pkg::PROD_W-1:0]     prod_r;
  logic [spb_pkg::QEST_W-1:0]     q_est;
  logic [spb_pkg::DIFF_W-1:0]     rem;
  logic [spb_pkg::DMS_W-1:0]      dms_calc;
  logic [spb_pkg::DMS_W-1:0]      dms_r;
  logic                           accept;
  logic                           bank_free;
  logic                           batch_full;

  assign now_t      = TIME_BITS'(in_now_us);
  assign in_ready   = (state_r == F_IDLE);
  assign accept     = in_valid && in_ready;
  assign bank_free  = !busy_r[bank_r];
  assign batch_full = (fill_r == FILL_W'(BATCH_DEPTH - 1));

  always_comb begin
    flags_set = flags_r;
    if (in_channel == spb_pkg::CHAN_0) begin
      flags_set[0] = 1'b1;
    end else if (in_channel == spb_pkg::CHAN_1) begin
      flags_set[1] = 1'b1;
    end
  end

  // Elapsed time; only the low bits matter unless the gap is exceeded
  assign start_eff = (fill_r == '0) ? now_r : start_r;
  assign diff      = now_r - start_eff;
  assign over_now  = (|diff[TIME_BITS-1:spb_pkg::DIFF_W]) ||
                     (diff[spb_pkg::DIFF_W-1:0] >= thresh_r);

  // Reciprocal estimate is low by at most one
  assign q_est    = prod_r[spb_pkg::RECIP_SHIFT +: spb_pkg::QEST_W];
  assign rem      = diff_lo_r - spb_pkg::DIFF_W'(q_est) * spb_pkg::US_PER_MS;
  assign dms_calc = (rem >= spb_pkg::US_PER_MS) ?
                    spb_pkg::DMS_W'(q_est) + spb_pkg::DMS_W'(1) : spb_pkg::DMS_W'(q_est);

  assign wr_en   = (state_r == F_WRITE) && bank_free;
  assign wr_addr = {bank_r, fill_r[IDX_W-1:0]};
  assign wr_data = {held0_r, held1_r, dms_r};

  always_comb begin
    flush_req           = '0;
    flush_req.cmd.bank  = bank_r;
    flush_req.cmd.stamp = spb_pkg::STAMP_W'(start_r);
    if (state_r == F_CORR && over_r) begin
      flush_req.valid     = 1'b1;
      flush_req.cmd.count = spb_pkg::CNT_W'(fill_r);
      flush_req.cmd.cause = spb_pkg::CAUSE_GAP;
    end else if (wr_en && batch_full) begin
      flush_req.valid     = 1'b1;
      flush_req.cmd.count = spb_pkg::CNT_W'(BATCH_DEPTH);
      flush_req.cmd.cause = spb_pkg::CAUSE_FULL;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (release_bank.valid) begin
      busy_nxt[release_bank.bank] = 1'b0;
    end
    if (flush_req.valid) begin
      busy_nxt[flush_req.cmd.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      flags_r  <= '0;
      held0_r  <= '0;
      held1_r  <= '0;
      fill_r   <= '0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
      thresh_r <= gap_to_thresh(spb_pkg::GAP_RESET);
      start_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (cfg_we) begin
        thresh_r <= gap_to_thresh(cfg_wdata);
      end
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            if (in_cmd == spb_pkg::CMD_RESTART) begin
              flags_r <= '0;
              fill_r  <= '0;
            end else begin
              if (in_channel == spb_pkg::CHAN_0) begin
                held0_r <= in_raw_code;
              end else if (in_channel == spb_pkg::CHAN_1) begin
                held1_r <= in_raw_code;
              end
              if (flags_set == 2'b11) begin
                flags_r <= '0;
                now_r   <= now_t;
                state_r <= F_DIFF;
              end else begin
                flags_r <= flags_set;
              end
            end
          end
        end
        F_DIFF: begin
          start_r   <= start_eff;
          diff_lo_r <= diff[spb_pkg::DIFF_W-1:0];
          over_r    <= over_now && (fill_r != '0);
          state_r   <= F_MUL;
        end
        F_MUL: begin
          prod_r  <= spb_pkg::PROD_W'(diff_lo_r) * spb_pkg::PROD_W'(spb_pkg::RECIP_MS);
          state_r <= F_CORR;
        end
        F_CORR: begin
          if (over_r) begin
            fill_r  <= '0;
            bank_r  <= ~bank_r;
            start_r <= now_r;
            dms_r   <= '0;
          end else begin
            dms_r <= dms_calc;
          end
          state_r <= F_WRITE;
        end
        F_WRITE: begin
          if (bank_free) begin
            if (batch_full) begin
              fill_r <= '0;
              bank_r <= ~bank_r;
            end else begin
              fill_r <= fill_r + FILL_W'(1);
            end
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/spb_cmd_queue.sv
// Two-entry queue of flush requests between front and back end.
// Depends on spb_pkg.
`default_nettype none

module spb_cmd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire spb_pkg::flush_req_t push,
  input  wire logic                pop,
  output spb_pkg::flush_cmd_t      head,
  output logic                     not_empty
);

  spb_pkg::flush_cmd_t mem_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          count_r;
  logic                do_push;
  logic                do_pop;

  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push.valid && (count_r != 2'd2);
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push.cmd;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/spb_back.sv
// Back end: drains a flushed bank from the RAM as a run of output entries.
// Depends on spb_pkg; reads spb_ram and pops spb_cmd_queue.
`default_nettype none

module spb_back #(
  parameter int BATCH_DEPTH = 8,
  localparam int IDX_W  = $clog2(BATCH_DEPTH),
  localparam int ADDR_W = IDX_W + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_not_empty,
  input  wire spb_pkg::flush_cmd_t          q_head,
  output logic                              q_pop,
  output logic                              rd_en,
  output logic      [ADDR_W-1:0]            rd_addr,
  input  wire logic [spb_pkg::ENTRY_W-1:0]  rd_data,
  output spb_pkg::bank_release_t            release_bank,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [spb_pkg::CODE_W-1:0]   out_ch0_code,
  output logic      [spb_pkg::CODE_W-1:0]   out_ch1_code,
  output logic      [spb_pkg::DMS_W-1:0]    out_delta_ms,
  output logic      [spb_pkg::STAMP_W-1:0]  out_start_time_us,
  output logic                              out_flush_cause,
  output logic                              out_last
);

  typedef enum logic [1:0] {B_IDLE, B_LOAD, B_HOLD} back_state_t;

  back_state_t         state_r;
  spb_pkg::flush_cmd_t cmd_r;
  logic [IDX_W-1:0]    idx_r;
  logic                entry_last;
  logic                taken;

  assign taken      = (state_r == B_HOLD) && out_ready;
  assign q_pop      = (state_r == B_IDLE) && q_not_empty;
  assign rd_en      = q_pop || (taken && !out_last);
  assign rd_addr    = (state_r == B_IDLE) ? {q_head.bank, IDX_W'(0)}
                                          : {cmd_r.bank, idx_r + IDX_W'(1)};
  assign entry_last = ((spb_pkg::CNT_W'(idx_r) + spb_pkg::CNT_W'(1)) == cmd_r.count);

  assign release_bank.valid = taken && out_last;
  assign release_bank.bank  = cmd_r.bank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (q_not_empty) begin
            cmd_r   <= q_head;
            idx_r   <= '0;
            state_r <= B_LOAD;
          end
        end
        B_LOAD: begin
          {out_ch0_code, out_ch1_code, out_delta_ms} <= rd_data;
          out_start_time_us <= cmd_r.stamp;
          out_flush_cause   <= cmd_r.cause;
          out_last          <= entry_last;
          out_valid         <= 1'b1;
          state_r           <= B_HOLD;
        end
        B_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state_r <= B_IDLE;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= B_LOAD;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for sample_pair_batcher_core: sends conversion and restart requests, predicts
// the pairing, batching and flush behaviour in-bench and checks every emitted batch entry.
// Depends on spb_pkg and sample_pair_batcher_core.

module tb;

  localparam int BATCH_LEN     = 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_OFF      = 400;
  localparam int MAX_REPORTS   = 40;
  localparam logic CMD_CONVERT = 1'b0;
  localparam logic [spb_pkg::STAMP_W-1:0] USEC_PER_MS = spb_pkg::STAMP_W'(1000);
  localparam logic [spb_pkg::STAMP_W-1:0] BASE_US     = 48'hA5A5_5A5A_0000;

  typedef struct packed {
    logic [spb_pkg::CODE_W-1:0]  ch0_code;
    logic [spb_pkg::CODE_W-1:0]  ch1_code;
    logic [spb_pkg::DMS_W-1:0]   delta_ms;
    logic [spb_pkg::STAMP_W-1:0] start_us;
    logic                        cause;
    logic                        last;
  } batch_entry_t;

  typedef struct packed {
    logic [spb_pkg::CODE_W-1:0] ch0_code;
    logic [spb_pkg::CODE_W-1:0] ch1_code;
    logic [spb_pkg::DMS_W-1:0]  delta_ms;
  } code_pair_t;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_cmd      = 1'b0;
  logic [spb_pkg::CHAN_W-1:0]  in_channel  = '0;
  logic [spb_pkg::CODE_W-1:0]  in_raw_code = '0;
  logic [spb_pkg::STAMP_W-1:0] in_now_us   = '0;
  logic                        out_ready   = 1'b0;
  logic                        cfg_we      = 1'b0;
  logic [spb_pkg::GAP_W-1:0]   cfg_wdata   = '0;
  logic                        in_ready;
  logic                        out_valid;
  logic [spb_pkg::CODE_W-1:0]  out_ch0_code;
  logic [spb_pkg::CODE_W-1:0]  out_ch1_code;
  logic [spb_pkg::DMS_W-1:0]   out_delta_ms;
  logic [spb_pkg::STAMP_W-1:0] out_start_time_us;
  logic                        out_flush_cause;
  logic                        out_last;

  // in-bench copy of the block state
  logic [spb_pkg::GAP_W-1:0]   gap_limit_ms = spb_pkg::GAP_RESET;
  logic [spb_pkg::CODE_W-1:0]  held_code0   = '0;
  logic [spb_pkg::CODE_W-1:0]  held_code1   = '0;
  logic [1:0]                  chan_ready   = '0;
  code_pair_t                  open_batch [BATCH_LEN];
  int                          batch_fill   = 0;
  logic [spb_pkg::STAMP_W-1:0] batch_start  = '0;
  batch_entry_t                due_entries [$];

  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int n_requests = 0;
  int n_entries = 0;
  int n_gap_flushes = 0;
  int n_full_flushes = 0;
  int n_mismatches = 0;

  sample_pair_batcher_core #(
    .BATCH_DEPTH(BATCH_LEN),
    .TIME_BITS  (spb_pkg::STAMP_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_channel       (in_channel),
    .in_raw_code      (in_raw_code),
    .in_now_us        (in_now_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ch0_code     (out_ch0_code),
    .out_ch1_code     (out_ch1_code),
    .out_delta_ms     (out_delta_ms),
    .out_start_time_us(out_start_time_us),
    .out_flush_cause  (out_flush_cause),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic emit_batch(input int count, input logic cause);
    batch_entry_t e;
    for (int i = 0; i < count; i++) begin
      e.ch0_code = open_batch[i].ch0_code;
      e.ch1_code = open_batch[i].ch1_code;
      e.delta_ms = open_batch[i].delta_ms;
      e.start_us = batch_start;
      e.cause    = cause;
      e.last     = (i == count - 1);
      due_entries.push_back(e);
    end
    if (cause == spb_pkg::CAUSE_GAP) n_gap_flushes++;
    else n_full_flushes++;
  endtask

  task automatic pair_and_batch(input logic cmd, input logic [spb_pkg::CHAN_W-1:0] chan,
                                input logic [spb_pkg::CODE_W-1:0] code,
                                input logic [spb_pkg::STAMP_W-1:0] now);
    logic [spb_pkg::STAMP_W-1:0] elapsed_ms;
    if (cmd == spb_pkg::CMD_RESTART) begin
      chan_ready = '0;
      batch_fill = 0;
      return;
    end
    if (chan == spb_pkg::CHAN_0) begin
      held_code0 = code;
      chan_ready[0] = 1'b1;
    end else if (chan == spb_pkg::CHAN_1) begin
      held_code1 = code;
      chan_ready[1] = 1'b1;
    end else begin
      return;
    end
    if (chan_ready != 2'b11) return;
    chan_ready = '0;
    if (batch_fill == 0) batch_start = now;
    elapsed_ms = (now - batch_start) / USEC_PER_MS;
    if (elapsed_ms > gap_limit_ms && batch_fill > 0) begin
      emit_batch(batch_fill, spb_pkg::CAUSE_GAP);
      batch_fill = 0;
      batch_start = now;
      elapsed_ms = '0;
    end
    open_batch[batch_fill] = '{held_code0, held_code1, elapsed_ms[spb_pkg::DMS_W-1:0]};
    batch_fill++;
    if (batch_fill == BATCH_LEN) begin
      emit_batch(BATCH_LEN, spb_pkg::CAUSE_FULL);
      batch_fill = 0;
    end
  endtask

  // valid is left high on return; the next request or a drain decides its next value
  task automatic send_request(input logic cmd, input logic [spb_pkg::CHAN_W-1:0] chan,
                              input logic [spb_pkg::CODE_W-1:0] code,
                              input logic [spb_pkg::STAMP_W-1:0] now);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_channel  <= chan;
    in_raw_code <= code;
    in_now_us   <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pair_and_batch(cmd, chan, code, now);
    n_requests++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (due_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(input logic [spb_pkg::GAP_W-1:0] gap);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= gap;
    @(posedge clk);
    gap_limit_ms = gap;
    cfg_we <= 1'b0;
  endtask

  task automatic send_pair(input logic [spb_pkg::CHAN_W-1:0] first,
                           input logic [spb_pkg::CODE_W-1:0] code0,
                           input logic [spb_pkg::CODE_W-1:0] code1,
                           input logic [spb_pkg::STAMP_W-1:0] now);
    if (first == spb_pkg::CHAN_0) begin
      send_request(CMD_CONVERT, spb_pkg::CHAN_0, code0, now);
      send_request(CMD_CONVERT, spb_pkg::CHAN_1, code1, now);
    end else begin
      send_request(CMD_CONVERT, spb_pkg::CHAN_1, code1, now);
      send_request(CMD_CONVERT, spb_pkg::CHAN_0, code0, now);
    end
  endtask

  // mostly complete pairs with advancing time; noisy runs add restarts, foreign
  // channels, repeated channels and time jumps
  task automatic send_random_requests(input int count, input int step_max, input bit noisy);
    logic [spb_pkg::STAMP_W-1:0] now;
    logic [spb_pkg::CHAN_W-1:0]  chan;
    bit                          second_half;
    int                          roll;
    int                          sent;
    now = spb_pkg::STAMP_W'({$urandom, $urandom});
    chan = spb_pkg::CHAN_0;
    second_half = 1'b0;
    sent = 0;
    while (sent < count) begin
      roll = noisy ? $urandom_range(0, 99) : 99;
      if (roll < 6) begin
        send_request(spb_pkg::CMD_RESTART, spb_pkg::CHAN_W'($urandom),
                     spb_pkg::CODE_W'($urandom), now);
        second_half = 1'b0;
        sent++;
      end else if (roll < 13) begin
        send_request(CMD_CONVERT, spb_pkg::CHAN_W'($urandom_range(2, 15)),
                     spb_pkg::CODE_W'($urandom), now);
      end else begin
        if (roll < 16) now = spb_pkg::STAMP_W'({$urandom, $urandom});
        else if (roll < 22) now += spb_pkg::STAMP_W'($urandom_range(0, 400_000));
        else now += spb_pkg::STAMP_W'($urandom_range(0, step_max));
        if (roll < 30 || !second_half) chan = spb_pkg::CHAN_W'($urandom_range(0, 1));
        else chan = (chan == spb_pkg::CHAN_0) ? spb_pkg::CHAN_1 : spb_pkg::CHAN_0;
        send_request(CMD_CONVERT, chan, spb_pkg::CODE_W'($urandom), now);
        second_half = !second_half;
        sent++;
      end
    end
  endtask

  task automatic test_discard_and_restart();
    send_request(CMD_CONVERT, 4'd15, 24'hFFFFFF, {spb_pkg::STAMP_W{1'b1}});
    send_request(CMD_CONVERT, 4'd2, 24'h000000, '0);
    send_request(CMD_CONVERT, spb_pkg::CHAN_0, 24'h000000, BASE_US);
    send_request(CMD_CONVERT, spb_pkg::CHAN_0, 24'h5A5A5A, BASE_US);
    send_request(spb_pkg::CMD_RESTART, 4'd15, 24'hFFFFFF, {spb_pkg::STAMP_W{1'b1}});
    send_request(CMD_CONVERT, spb_pkg::CHAN_1, 24'hFFFFFF, BASE_US);
    send_request(CMD_CONVERT, spb_pkg::CHAN_0, 24'h000001, BASE_US);
    send_pair(spb_pkg::CHAN_1, 24'h800000, 24'h7FFFFF, BASE_US + 48'd5000);
    send_request(spb_pkg::CMD_RESTART, 4'd0, 24'h000000, '0);
  endtask

  // batch starting at the top of the time range, filled across the wrap, then overtaken
  task automatic test_time_wrap_and_gap();
    send_pair(spb_pkg::CHAN_1, 24'hFFFFFF, 24'h000000, {spb_pkg::STAMP_W{1'b1}});
    send_pair(spb_pkg::CHAN_0, 24'h123456, 24'hABCDEF, 48'd254_999);
    send_pair(spb_pkg::CHAN_0, 24'h000000, 24'hFFFFFF, 48'd256_000);
  endtask

  task automatic test_gap_zero_and_one();
    write_gap(8'd0);
    send_pair(spb_pkg::CHAN_0, 24'h0F0F0F, 24'hF0F0F0, 48'd256_999);
    send_pair(spb_pkg::CHAN_1, 24'h333333, 24'hCCCCCC, 48'd257_000);
    write_gap(8'd1);
    send_pair(spb_pkg::CHAN_0, 24'hFFFFFF, 24'hFFFFFF, 48'd259_000);
  endtask

  task automatic test_random_settings();
    logic [spb_pkg::GAP_W-1:0] gap;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: gap = spb_pkg::GAP_RESET;
        1: gap = spb_pkg::GAP_W'($urandom_range(2, 254));
        2: gap = 8'd1;
        default: gap = 8'd0;
      endcase
      write_gap(gap);
      send_random_requests(18, (int'(gap) + 1) * 120, 1'b1);
    end
  endtask

  // receiver holds off while the sender keeps offering full batches
  task automatic test_backpressure();
    write_gap(spb_pkg::GAP_RESET);
    in_gaps_on = 1'b0;
    hold_cycles = HOLD_OFF;
    send_random_requests(48, 100, 1'b0);
    in_gaps_on = 1'b1;
  endtask

  task automatic test_full_rate();
    write_gap(spb_pkg::GAP_W'($urandom_range(2, 254)));
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    send_random_requests(24, 3000, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_discard_and_restart();
    test_time_wrap_and_gap();
    test_gap_zero_and_one();
    test_random_settings();
    test_backpressure();
    test_full_rate();
    drain_block();
    $display("Run covered %0d requests and %0d batch entries: %0d early flushes, %0d full",
             n_requests, n_entries, n_gap_flushes, n_full_flushes);
    $display("batches, gap limits 0, 1, 255 and random, with a long receiver hold-off.");
    if (n_mismatches == 0 && due_entries.size() == 0) begin
      $display("** sample_pair_batcher_core: PASSED **");
    end else begin
      $display("** sample_pair_batcher_core: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (out_gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    n_mismatches++;
    if (n_mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic check_entry();
    batch_entry_t want;
    if (due_entries.size() == 0) begin
      report_mismatch("unrequested entry", '0, 64'(out_ch0_code));
      return;
    end
    want = due_entries.pop_front();
    if (out_ch0_code !== want.ch0_code)
      report_mismatch("ch0_code", 64'(want.ch0_code), 64'(out_ch0_code));
    if (out_ch1_code !== want.ch1_code)
      report_mismatch("ch1_code", 64'(want.ch1_code), 64'(out_ch1_code));
    if (out_delta_ms !== want.delta_ms)
      report_mismatch("delta_ms", 64'(want.delta_ms), 64'(out_delta_ms));
    if (out_start_time_us !== want.start_us)
      report_mismatch("start_time_us", 64'(want.start_us), 64'(out_start_time_us));
    if (out_flush_cause !== want.cause)
      report_mismatch("flush_cause", 64'(want.cause), 64'(out_flush_cause));
    if (out_last !== want.last) report_mismatch("last", 64'(want.last), 64'(out_last));
    n_entries++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_entry();
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or entry moved for %0d cycles", $time, STALL_LIMIT);
      $display("** sample_pair_batcher_core: FAILED **");
      $finish;
    end
  end

endmodule

>>> sample_pair_batcher_core.f
src/spb_pkg.sv
src/spb_ram.sv
src/spb_front.sv
src/spb_cmd_queue.sv
src/spb_back.sv
src/sample_pair_batcher_core.sv
sim/tb.sv
